// File: rtl/sorq_pkg.sv
// sorq_pkg: shared constants, codes and types for the scan outbox retry queue
// depends on nothing; imported by sorq_ring and scan_outbox_retry_queue
`default_nettype none

package sorq_pkg;

    // ring geometry and entry layout
    localparam int DEPTH    = 32;
    localparam int TAG_BITS = 64;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // input item kinds
    localparam logic [1:0] MODE_SCAN    = 2'd0;
    localparam logic [1:0] MODE_POLL    = 2'd1;
    localparam logic [1:0] MODE_OUTCOME = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_ENDPOINT_OK = 3'd0;
    localparam logic [2:0] CFG_DUP_WINDOW  = 3'd1;
    localparam logic [2:0] CFG_RETRY_MIN   = 3'd2;
    localparam logic [2:0] CFG_RETRY_MAX   = 3'd3;
    localparam logic [2:0] CFG_MAX_PENDING = 3'd4;

    // reset values of configuration and backoff
    localparam logic [31:0] RST_DUP_WINDOW  = 32'd2500;
    localparam logic [31:0] RST_RETRY_MIN   = 32'd1000;
    localparam logic [31:0] RST_RETRY_MAX   = 32'd60000;
    localparam logic [5:0]  RST_MAX_PENDING = 6'd24;

    // http status boundaries
    localparam logic signed [10:0] HTTP_OK_LO      = 11'sd200;
    localparam logic signed [10:0] HTTP_OK_HI      = 11'sd300;
    localparam logic signed [10:0] HTTP_TOO_MANY   = 11'sd429;
    localparam logic signed [10:0] HTTP_SERVER_ERR = 11'sd500;
    localparam logic signed [10:0] HTTP_NOT_FOUND  = 11'sd404;

    // result codes
    typedef enum logic [3:0] {
        CODE_QUEUED     = 4'd0,
        CODE_DUPLICATE  = 4'd1,
        CODE_FULL       = 4'd2,
        CODE_SEND       = 4'd3,
        CODE_IDLE       = 4'd4,
        CODE_DELIVERED  = 4'd5,
        CODE_NOT_LINKED = 4'd6,
        CODE_REJECTED   = 4'd7,
        CODE_RETRY      = 4'd8,
        CODE_IGNORED    = 4'd9
    } t_code;

    // one queued scan event
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         seq;
        logic                kind;
    } t_entry;

    // ring write request
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        t_entry           data;
    } t_ring_wr;

endpackage

`default_nettype wire

// File: rtl/sorq_ring.sv
// sorq_ring: entry storage of the scan outbox, one write and one registered read port
// depends on sorq_pkg (DEPTH, t_entry, t_ring_wr)
`default_nettype none

module sorq_ring
    import sorq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_ring_wr         i_wr,
    input  wire logic [PTR_W-1:0] i_rd_addr,
    output t_entry                o_rd_data
);

    t_entry mem [DEPTH];
    t_entry r_rd_data;

    // write at the tail
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read of the head, new data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/scan_outbox_retry_queue.sv
// scan_outbox_retry_queue: a start goes through the input register, the decision logic
// and the result register to the o_valid strobe; one transaction per cycle, busy low outside
// reset; the ring read is registered and addressed with n_head_ptr
// synchronous active-low reset clears pointers, count; resets backoff, config; ring entries
// are not cleared and need no clearing pass; results cannot be stalled by the receiver
// depends on sorq_pkg and sorq_ring
`default_nettype none

module scan_outbox_retry_queue
    import sorq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic [63:0]        i_tag_uid,
    input  wire logic               i_scan_mode,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_link_up,
    input  wire logic signed [10:0] i_http_status,
    // result channel
    output logic                    o_valid,
    output logic [3:0]              o_code,
    output logic [63:0]             o_head_tag,
    output logic [31:0]             o_head_sequence,
    output logic                    o_head_scan_mode,
    output logic [5:0]              o_pending,
    output logic [31:0]             o_next_attempt_ms,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    // configuration registers
    logic        r_endpoint_ok;
    logic [31:0] r_dup_window_ms;
    logic [31:0] r_retry_min_ms;
    logic [31:0] r_retry_max_ms;
    logic [5:0]  r_max_pending;

    // input register
    logic                r_in_valid;
    logic [1:0]          r_in_mode;
    logic [TAG_BITS-1:0] r_in_tag;
    logic                r_in_kind;
    logic [31:0]         r_in_now;
    logic                r_in_link;
    logic signed [10:0]  r_in_status;

    // queue state
    logic [PTR_W-1:0]    r_head_ptr, n_head_ptr;
    logic [PTR_W-1:0]    r_tail_ptr, n_tail_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [31:0]         r_next_seq, n_next_seq;
    logic [31:0]         r_backoff_ms, n_backoff_ms;
    logic [31:0]         r_next_attempt, n_next_attempt;
    logic                r_awaiting, n_awaiting;
    logic [TAG_BITS-1:0] r_last_tag, n_last_tag;
    logic [31:0]         r_last_scan_at, n_last_scan_at;
    logic                r_have_last, n_have_last;

    // result register
    logic                r_out_valid;
    t_code               r_code, n_code;
    logic [TAG_BITS-1:0] r_out_tag, n_out_tag;
    logic [31:0]         r_out_seq, n_out_seq;
    logic                r_out_kind, n_out_kind;
    logic [CNT_W-1:0]    r_out_pending;
    logic [31:0]         r_out_next_attempt;

    // ring interface
    t_ring_wr ring_wr;
    t_entry   head_entry;

    // decision terms
    logic             is_dup;
    logic             is_full;
    logic             poll_not_due;
    logic [31:0]      since_scan;
    logic [31:0]      since_due;
    logic [32:0]      backoff_doubled;
    logic [31:0]      retry_backoff;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic             st_ok;
    logic             st_retry;

    // nothing is taken while reset is held
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    sorq_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd_addr (n_head_ptr),
        .o_rd_data (head_entry)
    );

    // shared arithmetic
    always_comb begin
        since_scan      = r_in_now - r_last_scan_at;
        since_due       = r_in_now - r_next_attempt;
        is_dup          = r_have_last && (r_in_tag == r_last_tag)
                          && (since_scan < r_dup_window_ms);
        is_full         = (32'(r_count) >= 32'(r_max_pending))
                          || (32'(r_count) >= 32'(DEPTH));
        poll_not_due    = since_due[31];
        backoff_doubled = {r_backoff_ms, 1'b0};
        retry_backoff   = (backoff_doubled > {1'b0, r_retry_max_ms})
                          ? r_retry_max_ms : backoff_doubled[31:0];
        head_inc        = (r_head_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_head_ptr + 1'b1;
        tail_inc        = (r_tail_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_tail_ptr + 1'b1;
        st_ok           = (r_in_status >= HTTP_OK_LO) && (r_in_status < HTTP_OK_HI);
        st_retry        = r_in_status[10] || (r_in_status == HTTP_TOO_MANY)
                          || (r_in_status >= HTTP_SERVER_ERR);
    end

    // per-item decision and next state
    always_comb begin
        n_head_ptr     = r_head_ptr;
        n_tail_ptr     = r_tail_ptr;
        n_count        = r_count;
        n_next_seq     = r_next_seq;
        n_backoff_ms   = r_backoff_ms;
        n_next_attempt = r_next_attempt;
        n_awaiting     = r_awaiting;
        n_last_tag     = r_last_tag;
        n_last_scan_at = r_last_scan_at;
        n_have_last    = r_have_last;
        n_code         = CODE_IGNORED;
        n_out_tag      = '0;
        n_out_seq      = '0;
        n_out_kind     = 1'b0;
        ring_wr.en     = 1'b0;
        ring_wr.addr   = r_tail_ptr;
        ring_wr.data.tag  = r_in_tag;
        ring_wr.data.seq  = r_next_seq;
        ring_wr.data.kind = r_in_kind;

        if (r_in_valid) begin
            case (r_in_mode)
                MODE_SCAN: begin
                    if (is_dup) begin
                        n_code = CODE_DUPLICATE;
                    end else begin
                        n_last_tag     = r_in_tag;
                        n_last_scan_at = r_in_now;
                        n_have_last    = 1'b1;
                        if (is_full) begin
                            n_code = CODE_FULL;
                        end else begin
                            ring_wr.en = 1'b1;
                            n_tail_ptr = tail_inc;
                            n_count    = r_count + 1'b1;
                            n_out_seq  = r_next_seq;
                            n_next_seq = (r_next_seq == '1) ? 32'd1 : r_next_seq + 32'd1;
                            n_code     = CODE_QUEUED;
                        end
                    end
                end
                MODE_POLL: begin
                    if ((r_count == '0) || !r_endpoint_ok || r_awaiting || poll_not_due) begin
                        n_code = CODE_IDLE;
                    end else if (!r_in_link) begin
                        n_next_attempt = r_in_now + r_backoff_ms;
                        n_backoff_ms   = retry_backoff;
                        n_code         = CODE_RETRY;
                    end else begin
                        n_awaiting = 1'b1;
                        n_out_tag  = head_entry.tag;
                        n_out_seq  = head_entry.seq;
                        n_out_kind = head_entry.kind;
                        n_code     = CODE_SEND;
                    end
                end
                MODE_OUTCOME: begin
                    if (r_awaiting && (r_count != '0)) begin
                        n_awaiting = 1'b0;
                        if (!st_ok && st_retry) begin
                            n_next_attempt = r_in_now + r_backoff_ms;
                            n_backoff_ms   = retry_backoff;
                            n_code         = CODE_RETRY;
                        end else begin
                            // entry leaves the queue
                            n_head_ptr     = head_inc;
                            n_count        = r_count - 1'b1;
                            n_backoff_ms   = r_retry_min_ms;
                            n_next_attempt = r_in_now;
                            if (st_ok) begin
                                n_code = CODE_DELIVERED;
                            end else if (r_in_status == HTTP_NOT_FOUND) begin
                                n_code = CODE_NOT_LINKED;
                            end else begin
                                n_code = CODE_REJECTED;
                            end
                        end
                    end
                end
                default: begin
                    n_code = CODE_IGNORED;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_endpoint_ok   <= 1'b1;
            r_dup_window_ms <= RST_DUP_WINDOW;
            r_retry_min_ms  <= RST_RETRY_MIN;
            r_retry_max_ms  <= RST_RETRY_MAX;
            r_max_pending   <= RST_MAX_PENDING;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENDPOINT_OK: r_endpoint_ok   <= i_cfg_data[0];
                CFG_DUP_WINDOW:  r_dup_window_ms <= i_cfg_data;
                CFG_RETRY_MIN:   r_retry_min_ms  <= i_cfg_data;
                CFG_RETRY_MAX:   r_retry_max_ms  <= i_cfg_data;
                CFG_MAX_PENDING: r_max_pending   <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // input register: capture the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_mode   <= i_mode;
            r_in_tag    <= i_tag_uid[TAG_BITS-1:0];
            r_in_kind   <= i_scan_mode;
            r_in_now    <= i_now_ms;
            r_in_link   <= i_link_up;
            r_in_status <= i_http_status;
        end
    end

    // queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr     <= '0;
            r_tail_ptr     <= '0;
            r_count        <= '0;
            r_next_seq     <= 32'd1;
            r_backoff_ms   <= RST_RETRY_MIN;
            r_next_attempt <= '0;
            r_awaiting     <= 1'b0;
            r_last_tag     <= '0;
            r_last_scan_at <= '0;
            r_have_last    <= 1'b0;
        end else begin
            r_head_ptr     <= n_head_ptr;
            r_tail_ptr     <= n_tail_ptr;
            r_count        <= n_count;
            r_next_seq     <= n_next_seq;
            r_backoff_ms   <= n_backoff_ms;
            r_next_attempt <= n_next_attempt;
            r_awaiting     <= n_awaiting;
            r_last_tag     <= n_last_tag;
            r_last_scan_at <= n_last_scan_at;
            r_have_last    <= n_have_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code             <= n_code;
        r_out_tag          <= n_out_tag;
        r_out_seq          <= n_out_seq;
        r_out_kind         <= n_out_kind;
        r_out_pending      <= n_count;
        r_out_next_attempt <= n_next_attempt;
    end

    assign o_valid           = r_out_valid;
    assign o_code            = r_code;
    assign o_head_tag        = 64'(r_out_tag);
    assign o_head_sequence   = r_out_seq;
    assign o_head_scan_mode  = r_out_kind;
    assign o_pending         = 6'(r_out_pending);
    assign o_next_attempt_ms = r_out_next_attempt;

endmodule

`default_nettype wire
